FILE: src/stacked_biquad_hipass_lopass_core_macros.svh
// Assertion macros used by the checker file of the biquad cascade.
// No dependencies; include by bare file name.
`ifndef STACKED_BIQUAD_HIPASS_LOPASS_CORE_MACROS_SVH
`define STACKED_BIQUAD_HIPASS_LOPASS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBQ_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbq checker: same-cycle rule violated");

// Consequent must hold in the cycle after the antecedent.
`define SBQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbq checker: next-cycle rule violated");

`endif

FILE: src/sbq_pkg.sv
// Package for the stacked biquad cascade: widths, types, register codes,
// rounding and saturation helpers. No dependencies.
`default_nettype none

package sbq_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int COEF_FRAC_BITS  = 19;
    localparam int STATE_BITS      = 40;
    localparam int COEF_FIELD_BITS = 21;
    localparam int SPLIT_BITS      = 24;
    localparam int COEF_WORD_BITS  = 3 * COEF_FIELD_BITS;
    localparam int WIDE_BITS       = STATE_BITS + COEF_FIELD_BITS + 2;
    localparam int MOP_BITS        = SPLIT_BITS + 1;
    localparam int MPROD_BITS      = MOP_BITS + COEF_FIELD_BITS;

    localparam int NUM_CELLS       = 6;
    localparam int HP_CELLS        = 3;
    localparam int CFG_INDEX_BITS  = 3;

    typedef logic signed [SAMPLE_BITS-1:0]     sample_t;
    typedef logic signed [STATE_BITS-1:0]      state_t;
    typedef logic signed [WIDE_BITS-1:0]       wide_t;
    typedef logic signed [COEF_FIELD_BITS-1:0] coef_t;
    typedef logic signed [MOP_BITS-1:0]        mop_t;
    typedef logic signed [MPROD_BITS-1:0]      mprod_t;

    typedef struct packed {
        logic engage;
        logic a1_neg;
        logic clear_on_bypass;
    } cell_ctrl_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_HP_STAGE1 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HP_STAGE2 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HP_STAGE3 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LP_STAGE1 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LP_STAGE2 = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LP_STAGE3 = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HP_ENGAGE = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LP_ENGAGE = 3'd7;

    localparam wide_t ROUND_HALF = wide_t'(1) <<< (COEF_FRAC_BITS - 1);
    localparam wide_t STATE_MAX_W =
        {{(WIDE_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    localparam wide_t STATE_MIN_W =
        {{(WIDE_BITS-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};
    localparam state_t SAMPLE_MAX_S =
        {{(STATE_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam state_t SAMPLE_MIN_S =
        {{(STATE_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    // round-half-up of a raw product back to sample LSB units
    function automatic wide_t rnd_prod(input wide_t v);
        return (v + ROUND_HALF) >>> COEF_FRAC_BITS;
    endfunction

    function automatic state_t sat_state(input wide_t v);
        wide_t c;
        c = v;
        if (v > STATE_MAX_W) begin
            c = STATE_MAX_W;
        end else if (v < STATE_MIN_W) begin
            c = STATE_MIN_W;
        end
        return c[STATE_BITS-1:0];
    endfunction

    function automatic sample_t sat_sample(input state_t v);
        state_t c;
        c = v;
        if (v > SAMPLE_MAX_S) begin
            c = SAMPLE_MAX_S;
        end else if (v < SAMPLE_MIN_S) begin
            c = SAMPLE_MIN_S;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/sbq_cell.sv
// One transposed DF-II biquad cell with its own delay pair and a shared
// split multiplier. Depends on sbq_pkg.
`default_nettype none

module sbq_cell
    import sbq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cell_ctrl_t                ctrl,
    input  logic [COEF_WORD_BITS-1:0] coef_word,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  state_t                    in_x,
    output logic                      out_valid,
    input  logic                      out_ready,
    output state_t                    out_y
);

    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] S_IDLE = 4'd0;
    localparam logic [STEP_BITS-1:0] S_MXL  = 4'd1;
    localparam logic [STEP_BITS-1:0] S_MXH  = 4'd2;
    localparam logic [STEP_BITS-1:0] S_PX   = 4'd3;
    localparam logic [STEP_BITS-1:0] S_Y    = 4'd4;
    localparam logic [STEP_BITS-1:0] S_MYL1 = 4'd5;
    localparam logic [STEP_BITS-1:0] S_MYH1 = 4'd6;
    localparam logic [STEP_BITS-1:0] S_MYL2 = 4'd7;
    localparam logic [STEP_BITS-1:0] S_MYH2 = 4'd8;
    localparam logic [STEP_BITS-1:0] S_D1   = 4'd9;
    localparam logic [STEP_BITS-1:0] S_DONE = 4'd10;

    logic [STEP_BITS-1:0] state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    state_t               d0_reg, d0_next;
    state_t               d1_reg, d1_next;
    state_t               x_reg, x_next;
    state_t               y_reg, y_next;
    wide_t                acc_reg, acc_next;
    wide_t                pa_reg, pa_next;
    wide_t                ta_reg, ta_next;
    mprod_t               prod_reg;

    coef_t  a0, b1, b2;
    state_t mul_val;
    coef_t  mul_coef;
    logic   mul_hi;
    mop_t   mul_a;
    mprod_t mul_p;
    wide_t  acc_lo;
    wide_t  acc_hi;
    wide_t  acc_rnd;
    wide_t  two_p;

    assign a0 = coef_word[COEF_FIELD_BITS-1:0];
    assign b1 = coef_word[2*COEF_FIELD_BITS-1:COEF_FIELD_BITS];
    assign b2 = coef_word[3*COEF_FIELD_BITS-1:2*COEF_FIELD_BITS];

    // operand select: value split into unsigned low part and signed high part
    always_comb begin
        mul_val  = x_reg;
        mul_coef = a0;
        mul_hi   = 1'b0;
        case (state_reg)
            S_MXL: begin
            end
            S_MXH: begin
                mul_hi = 1'b1;
            end
            S_MYL1: begin
                mul_val  = y_reg;
                mul_coef = b1;
            end
            S_MYH1: begin
                mul_val  = y_reg;
                mul_coef = b1;
                mul_hi   = 1'b1;
            end
            S_MYL2: begin
                mul_val  = y_reg;
                mul_coef = b2;
            end
            S_MYH2: begin
                mul_val  = y_reg;
                mul_coef = b2;
                mul_hi   = 1'b1;
            end
            default: begin
            end
        endcase
        if (mul_hi) begin
            mul_a = mop_t'($signed(mul_val[STATE_BITS-1:SPLIT_BITS]));
        end else begin
            mul_a = $signed({1'b0, mul_val[SPLIT_BITS-1:0]});
        end
    end

    assign mul_p   = mul_a * mul_coef;
    assign acc_lo  = wide_t'(prod_reg);
    assign acc_hi  = acc_reg + (wide_t'(prod_reg) <<< SPLIT_BITS);
    assign acc_rnd = rnd_prod(acc_reg);
    assign two_p   = acc_reg <<< 1;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_y     = y_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        pa_next        = pa_reg;
        ta_next        = ta_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    if (ctrl.engage) begin
                        x_next     = in_x;
                        state_next = S_MXL;
                    end else begin
                        y_next         = in_x;
                        out_valid_next = 1'b1;
                        if (ctrl.clear_on_bypass) begin
                            d0_next = '0;
                            d1_next = '0;
                        end
                    end
                end
            end
            S_MXL: begin
                state_next = S_MXH;
            end
            S_MXH: begin
                acc_next   = acc_lo;
                state_next = S_PX;
            end
            S_PX: begin
                acc_next   = acc_hi;
                state_next = S_Y;
            end
            S_Y: begin
                // acc holds x*a0; a1 product is exactly twice it, negated when a1_neg is set
                pa_next    = acc_rnd;
                ta_next    = ctrl.a1_neg ? rnd_prod(-two_p) : rnd_prod(two_p);
                y_next     = sat_state(acc_rnd + wide_t'(d0_reg));
                state_next = S_MYL1;
            end
            S_MYL1: begin
                state_next = S_MYH1;
            end
            S_MYH1: begin
                acc_next   = acc_lo;
                state_next = S_MYL2;
            end
            S_MYL2: begin
                acc_next   = acc_hi;
                state_next = S_MYH2;
            end
            S_MYH2: begin
                d0_next    = sat_state(ta_reg - acc_rnd + wide_t'(d1_reg));
                acc_next   = acc_lo;
                state_next = S_D1;
            end
            S_D1: begin
                acc_next   = acc_hi;
                state_next = S_DONE;
            end
            S_DONE: begin
                d1_next        = sat_state(pa_reg - acc_rnd);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            d0_reg        <= '0;
            d1_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            d0_reg        <= d0_next;
            d1_reg        <= d1_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        pa_reg   <= pa_next;
        ta_reg   <= ta_next;
        prod_reg <= mul_p;
    end

endmodule

`default_nettype wire

FILE: src/stacked_biquad_hipass_lopass_core.sv
// Each engaged cell steps through its compute states before it hands a
//   result on; a bypassed cell registers its sample straight to its output.
// A cell takes no new sample while busy or while still holding a result;
//   each engaged cell's single 25x21 multiplier runs six partial products
//   per sample and paces the chain.
// Reset (aresetn, sync, active low): clears all delays, coefficients, engage
//   bits and handshake state; s_ready is high in the first cycle after reset.
`default_nettype none

// Top level: config registers and a chain of six biquad cells.
// Depends on sbq_pkg and sbq_cell.
module stacked_biquad_hipass_lopass_core
    import sbq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_WORD_BITS-1:0] cfg_wdata,
    // sample input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  sample_t                   s_sample_in,
    // filtered sample output channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output sample_t                   m_sample_out
);

    // Coefficient words, one per cell: highpass stages first, then lowpass.
    logic [COEF_WORD_BITS-1:0] coef_reg  [NUM_CELLS];
    logic [COEF_WORD_BITS-1:0] coef_next [NUM_CELLS];
    logic                      hp_engage_reg, hp_engage_next;
    logic                      lp_engage_reg, lp_engage_next;

    // Links between cells: link i feeds cell i, link i+1 is its output.
    logic   link_valid [NUM_CELLS+1];
    logic   link_ready [NUM_CELLS+1];
    state_t link_data  [NUM_CELLS+1];

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the chain
    // is idle, so no shadowing is needed; the block does not enforce it.
    // ------------------------------------------------------------------
    always_comb begin
        coef_next      = coef_reg;
        hp_engage_next = hp_engage_reg;
        lp_engage_next = lp_engage_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_HP_STAGE1, REG_HP_STAGE2, REG_HP_STAGE3,
                REG_LP_STAGE1, REG_LP_STAGE2, REG_LP_STAGE3: begin
                    coef_next[cfg_index] = cfg_wdata;
                end
                REG_HP_ENGAGE: begin
                    hp_engage_next = cfg_wdata[0];
                end
                REG_LP_ENGAGE: begin
                    lp_engage_next = cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CELLS; i++) begin
                coef_reg[i] <= '0;
            end
            hp_engage_reg <= 1'b0;
            lp_engage_reg <= 1'b0;
        end else begin
            coef_reg      <= coef_next;
            hp_engage_reg <= hp_engage_next;
            lp_engage_reg <= lp_engage_next;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. The input sample is widened to the state width; each
    // cell hands its result to the next through a valid/ready link.
    // ------------------------------------------------------------------
    assign link_valid[0] = s_valid;
    assign s_ready       = link_ready[0];
    assign link_data[0]  = state_t'(s_sample_in);

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        cell_ctrl_t ctrl;

        // Highpass cells use a1 = -2*a0; only the first highpass cell
        // wipes its delays when it passes a sample with the highpass off.
        assign ctrl = '{
            engage:          (i < HP_CELLS) ? hp_engage_reg : lp_engage_reg,
            a1_neg:          (i < HP_CELLS),
            clear_on_bypass: (i == 0)
        };

        sbq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .coef_word (coef_reg[i]),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_x      (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_y     (link_data[i+1])
        );
    end

    // Last cell's output register is the result register; clamp to the
    // sample range on the way out.
    assign m_valid               = link_valid[NUM_CELLS];
    assign link_ready[NUM_CELLS] = m_ready;
    assign m_sample_out          = sat_sample(link_data[NUM_CELLS]);

endmodule

`default_nettype wire

FILE: src/sbq_checker.sv
// Port-level checker for the biquad cascade top level, bound to it below.
// Depends on sbq_pkg and stacked_biquad_hipass_lopass_core_macros.svh.
`default_nettype none
`include "stacked_biquad_hipass_lopass_core_macros.svh"

module sbq_checker
    import sbq_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input sample_t                   s_sample_in,
    input logic                      m_valid,
    input logic                      m_ready,
    input sample_t                   m_sample_out
);

    // stalled result holds
    `SBQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_out))

    // waiting input transaction holds
    `SBQ_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_sample_in))

    // first cell is busy or holding a result right after taking a sample
    `SBQ_ASSERT_NEXT(a_in_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready)

    // chain comes out of reset empty and ready
    `SBQ_ASSERT_SAME(a_reset_clean, aclk, aresetn, $rose(aresetn), !m_valid && s_ready)

endmodule

bind stacked_biquad_hipass_lopass_core sbq_checker u_sbq_checker (.*);

`default_nettype wire

FILE: tb/stacked_biquad_hipass_lopass_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the six-stage highpass/lowpass biquad cascade.
// Depends on sbq_pkg and stacked_biquad_hipass_lopass_core; no files read.

module stacked_biquad_hipass_lopass_core_test;
    import sbq_pkg::*;

    localparam int RUN_LIMIT    = 400000;  // cycles before we call it a hang
    localparam int PHASE_ITEMS  = 80;
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_CYCLES = 70;      // a bit more than the full cascade latency

    localparam sample_t FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam bit [COEF_FIELD_BITS-1:0] COEF_MAX = {1'b0, {(COEF_FIELD_BITS-1){1'b1}}};
    localparam bit [COEF_FIELD_BITS-1:0] COEF_MIN = {1'b1, {(COEF_FIELD_BITS-1){1'b0}}};

    localparam logic [CFG_INDEX_BITS-1:0] COEF_REGS [NUM_CELLS] = '{
        REG_HP_STAGE1, REG_HP_STAGE2, REG_HP_STAGE3,
        REG_LP_STAGE1, REG_LP_STAGE2, REG_LP_STAGE3
    };

    // engage plan per random phase (bit = phase number): both, hp only,
    // lp only, both, both, neither, both, hp only
    localparam bit [NUM_PHASES-1:0] HP_PLAN = 8'b1101_1011;
    localparam bit [NUM_PHASES-1:0] LP_PLAN = 8'b0101_1101;

    // ---------------------------------------------------------------
    // Scoreboard: bit-exact cascade predictor plus the queue of samples
    // the block still owes us.
    // ---------------------------------------------------------------
    class filter_scoreboard;
        bit [COEF_WORD_BITS-1:0] coef_word [NUM_CELLS];
        bit      hp_on;
        bit      lp_on;
        longint  hp_dly [NUM_CELLS];
        longint  lp_dly [NUM_CELLS];
        sample_t expected_out [$];
        int      mismatches;
        int      results_seen;

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [COEF_WORD_BITS-1:0] val);
            case (idx)
                REG_HP_ENGAGE: hp_on = val[0];
                REG_LP_ENGAGE: lp_on = val[0];
                default:       coef_word[idx] = val;
            endcase
        endfunction

        // product rounded half up back to sample LSB units (floor after bias)
        static function longint round_mul(longint x, longint c);
            return (x * c + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        endfunction

        static function longint clamp(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // one transposed DF-II section; a2 == a0, a1 = -/+ 2*a0
        function longint run_cell(bit hipass, int k, longint x);
            bit [COEF_WORD_BITS-1:0] w;
            longint a0, a1, b1, b2, d0, d1, pa, y;
            w  = coef_word[hipass ? k : HP_CELLS + k];
            a0 = $signed(w[COEF_FIELD_BITS-1:0]);
            b1 = $signed(w[2*COEF_FIELD_BITS-1:COEF_FIELD_BITS]);
            b2 = $signed(w[3*COEF_FIELD_BITS-1:2*COEF_FIELD_BITS]);
            a1 = hipass ? -2 * a0 : 2 * a0;
            if (hipass) begin
                d0 = hp_dly[2*k];
                d1 = hp_dly[2*k+1];
            end else begin
                d0 = lp_dly[2*k];
                d1 = lp_dly[2*k+1];
            end
            pa = round_mul(x, a0);
            y  = clamp(pa + d0, STATE_BITS);
            d0 = clamp(round_mul(x, a1) - round_mul(y, b1) + d1, STATE_BITS);
            d1 = clamp(pa - round_mul(y, b2), STATE_BITS);
            if (hipass) begin
                hp_dly[2*k]   = d0;
                hp_dly[2*k+1] = d1;
            end else begin
                lp_dly[2*k]   = d0;
                lp_dly[2*k+1] = d1;
            end
            return y;
        endfunction

        function void note_input(sample_t s);
            longint x;
            x = s;
            if (hp_on) begin
                for (int k = 0; k < HP_CELLS; k++) x = run_cell(1'b1, k, x);
            end else begin
                // bypass wipes only the first highpass section
                hp_dly[0] = 0;
                hp_dly[1] = 0;
            end
            if (lp_on) begin
                for (int k = 0; k < NUM_CELLS - HP_CELLS; k++) x = run_cell(1'b0, k, x);
            end
            expected_out.push_back(sample_t'(clamp(x, SAMPLE_BITS)));
        endfunction

        function void check_output(sample_t got);
            sample_t want;
            results_seen++;
            if (expected_out.size() == 0) begin
                $display("%0t: sample_out %0d arrived with nothing pending", $time, got);
                mismatches++;
            end else begin
                want = expected_out.pop_front();
                if (got !== want) begin
                    $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                             $time, want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    // ---------------------------------------------------------------
    // DUT hookup
    // ---------------------------------------------------------------
    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [COEF_WORD_BITS-1:0] cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    sample_t                   s_sample_in = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    sample_t                   m_sample_out;

    filter_scoreboard sb;
    int send_idle_pct  = 0;   // chance per cycle the sender holds off
    int recv_stall_pct = 0;   // chance per cycle the receiver drops ready
    int samples_sent   = 0;
    int settings_run   = 0;
    int cycle_count    = 0;
    int total_errors;

    stacked_biquad_hipass_lopass_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    always #6 aclk = ~aclk;

    // Hang guard. A correct run finishes far below this.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Transaction monitor: sees pre-edge values, so no race with the drivers.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_sample_in);
            if (m_valid && m_ready) sb.check_output(m_sample_out);
        end
    end

    // ---------------------------------------------------------------
    // Drivers and stimulus helpers
    // ---------------------------------------------------------------
    // Register write takes effect at the next edge; the model follows it.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [COEF_WORD_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // Present one sample, with an optional random gap first; valid stays up
    // across back-to-back transactions.
    task automatic push_sample(input sample_t v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= v;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // Stop sending and let every owed result come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.results_seen < samples_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic sample_t pick_sample();
        int r;
        int small_val;
        r = $urandom_range(99);
        small_val = int'($urandom_range(2047)) - 1024;
        if (r < 8) return FULL_POS;
        if (r < 16) return FULL_NEG;
        if (r < 36) return sample_t'(small_val);
        return sample_t'($urandom());
    endfunction

    function automatic bit [COEF_FIELD_BITS-1:0] edge_coef();
        case ($urandom_range(3))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Mostly well-behaved sections (poles inside the unit circle) so state
    // builds up over many samples; the rest raw bit patterns and rail values.
    function automatic bit [COEF_WORD_BITS-1:0] pick_coefs();
        int r;
        int b2_i;
        int b1_i;
        bit [COEF_FIELD_BITS-1:0] a0, b1, b2;
        bit [63:0] raw;
        r = $urandom_range(99);
        if (r < 70) begin
            b2_i = $urandom_range(471859);                       // 0 .. 0.9
            b1_i = $urandom_range(((1 << COEF_FRAC_BITS) + b2_i) * 9 / 10);
            if ($urandom_range(1)) b1_i = -b1_i;
            a0 = COEF_FIELD_BITS'($urandom_range(1 << 17));
            b1 = COEF_FIELD_BITS'(b1_i);
            b2 = COEF_FIELD_BITS'(b2_i);
            return {b2, b1, a0};
        end
        if (r < 90) begin
            raw = {$urandom(), $urandom()};
            return raw[COEF_WORD_BITS-1:0];
        end
        return {edge_coef(), edge_coef(), edge_coef()};
    endfunction

    // Engage word with junk above bit 0: only the low bit may matter.
    function automatic bit [COEF_WORD_BITS-1:0] engage_word(input bit on);
        bit [63:0] raw;
        raw    = {$urandom(), $urandom()};
        raw[0] = on;
        return raw[COEF_WORD_BITS-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset both cascades are bypassed: samples come straight out.
        settings_run++;
        push_sample(FULL_POS);
        push_sample(FULL_NEG);
        push_sample('0);
        push_sample('1);
        push_sample(sample_t'(1));
        wait_idle();

        // Highpass on with reset (zero) coefficients gives silence; lowpass
        // write with only bit 1 set must leave it off.
        write_reg(REG_HP_ENGAGE, '1);
        write_reg(REG_LP_ENGAGE, COEF_WORD_BITS'(2));
        cfg_wr_en <= 1'b0;
        settings_run++;
        push_sample(FULL_POS);
        push_sample(FULL_NEG);
        wait_idle();

        // Rail coefficients in the highpass, all-ones words in the lowpass, both
        // cascades on: drives every saturation point, including the final clamp to sample range.
        for (int k = 0; k < HP_CELLS; k++) write_reg(COEF_REGS[k], {COEF_MAX, COEF_MIN, COEF_MAX});
        for (int k = HP_CELLS; k < NUM_CELLS; k++) write_reg(COEF_REGS[k], '1);
        write_reg(REG_LP_ENGAGE, '1);
        cfg_wr_en <= 1'b0;
        settings_run++;
        push_sample(FULL_POS);
        push_sample(FULL_NEG);
        push_sample(FULL_POS);
        push_sample('0);
        push_sample(FULL_NEG);
        push_sample(sample_t'(1));
        wait_idle();

        // Highpass bypass: clears only section one, the others keep state.
        write_reg(REG_HP_ENGAGE, {{(COEF_WORD_BITS-1){1'b1}}, 1'b0});
        cfg_wr_en <= 1'b0;
        settings_run++;
        push_sample(sample_t'(1000));
        push_sample(sample_t'(-1000));
        push_sample(FULL_POS);
        push_sample(FULL_NEG);
        wait_idle();

        // Back on with lowpass bypassed: leftover section two/three state shows.
        write_reg(REG_HP_ENGAGE, COEF_WORD_BITS'(1));
        write_reg(REG_LP_ENGAGE, '0);
        cfg_wr_en <= 1'b0;
        settings_run++;
        push_sample('0);
        push_sample('0);
        push_sample(sample_t'(12345));
        push_sample('1);
        wait_idle();

        // Random phases: fresh settings each time, idling pattern rotates
        // through none / sender gaps / receiver stalls / both lightly.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                default: begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            for (int k = 0; k < NUM_CELLS; k++) write_reg(COEF_REGS[k], pick_coefs());
            write_reg(REG_HP_ENGAGE, engage_word(HP_PLAN[ph]));
            write_reg(REG_LP_ENGAGE, engage_word(LP_PLAN[ph]));
            cfg_wr_en <= 1'b0;
            settings_run++;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // halfway through, starve the pipe completely once
                if (i == PHASE_ITEMS / 2) wait_idle();
                push_sample(pick_sample());
            end
            wait_idle();
        end

        // Catch any stray result after the last one owed.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        total_errors = sb.mismatches + sb.expected_out.size();
        $display("Checked %0d filtered samples over %0d filter settings: rails, bypass",
                 sb.results_seen, settings_run);
        $display("paths and random sections under sender gaps and receiver stalls.");
        if (total_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
